// File: src/arc_chord_length_bounds_assert.svh
// assertion macros for the arc chord bound block
`ifndef ARC_CHORD_LENGTH_BOUNDS_ASSERT_SVH
`define ARC_CHORD_LENGTH_BOUNDS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ACB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never seen
`define ACB_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: src/acb_pkg.sv
// shared types and constants for the arc chord bound block
package acb_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam int IN_W          = 32;
    localparam int OUT_W         = 33;

    typedef struct packed {
        logic signed [IN_W-1:0] point_x;
        logic signed [IN_W-1:0] point_y;
        logic signed [IN_W-1:0] point_z;
        logic signed [IN_W-1:0] start_x;
        logic signed [IN_W-1:0] start_y;
        logic signed [IN_W-1:0] start_z;
        logic signed [IN_W-1:0] end_x;
        logic signed [IN_W-1:0] end_y;
        logic signed [IN_W-1:0] end_z;
        logic signed [IN_W-1:0] normal_x;
        logic signed [IN_W-1:0] normal_y;
        logic signed [IN_W-1:0] normal_z;
    } acb_req_t;

    typedef struct packed {
        logic [OUT_W-1:0] min_chord_sq;
        logic [OUT_W-1:0] max_chord_sq;
        logic             min_interior;
        logic             max_interior;
    } acb_rsp_t;

endpackage

// File: src/arc_chord_length_bounds.sv
// arc chord bounds: pipelined cross products, dot products and a ratio square root
// done follows an accepted request through the product, square root and output stages
// one request per cycle, busy never rises, one result per request in request order
// the depth is set by the square root pipeline, one stage per result bit (FRAC_BITS + 3)
// rst_n clears the valid pipeline only; no request is lost across cycles outside reset
`include "arc_chord_length_bounds_assert.svh"

module arc_chord_length_bounds
    import acb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  acb_req_t request,
    output logic     done,
    output acb_rsp_t result
);

    localparam int NSQ = FRAC_BITS + 3;
    localparam int QW  = NSQ;
    localparam int DW  = 2 * FRAC_BITS + 138;
    localparam int MW  = FRAC_BITS + 2;
    localparam int EW  = (FRAC_BITS + 4 > 34) ? FRAC_BITS + 4 : 34;
    localparam int LAT = NSQ + 7;
    localparam logic [EW-1:0]    TWO_E    = EW'(1) << (FRAC_BITS + 1);
    localparam logic [EW-1:0]    FOUR_E   = EW'(1) << (FRAC_BITS + 2);
    localparam logic [OUT_W-1:0] TWO_SAT  = (|TWO_E[EW-1:OUT_W]) ? '1 : TWO_E[OUT_W-1:0];
    localparam logic [OUT_W-1:0] FOUR_SAT = (|FOUR_E[EW-1:OUT_W]) ? '1 : FOUR_E[OUT_W-1:0];

    logic signed [IN_W-1:0] in_v [3];
    logic signed [IN_W-1:0] in_n [3];
    logic signed [IN_W-1:0] in_a [3];
    logic signed [IN_W-1:0] in_b [3];

    assign in_v[0] = request.point_x;
    assign in_v[1] = request.point_y;
    assign in_v[2] = request.point_z;
    assign in_n[0] = request.normal_x;
    assign in_n[1] = request.normal_y;
    assign in_n[2] = request.normal_z;
    assign in_a[0] = request.start_x;
    assign in_a[1] = request.start_y;
    assign in_a[2] = request.start_z;
    assign in_b[0] = request.end_x;
    assign in_b[1] = request.end_y;
    assign in_b[2] = request.end_z;

    assign busy = 1'b0;

    // valid pipeline
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign vld_next = {vld_reg[LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done = vld_reg[LAT-1];

    // stage 1: component products
    logic signed [63:0]     s1_x_reg [6];
    logic signed [63:0]     s1_x_next [6];
    logic signed [63:0]     s1_d_reg [3];
    logic signed [63:0]     s1_d_next [3];
    logic signed [IN_W-1:0] s1_a_reg [3];
    logic signed [IN_W-1:0] s1_b_reg [3];

    always_comb
    begin
        s1_x_next[0] = in_v[1] * in_n[2];
        s1_x_next[1] = in_v[2] * in_n[1];
        s1_x_next[2] = in_v[2] * in_n[0];
        s1_x_next[3] = in_v[0] * in_n[2];
        s1_x_next[4] = in_v[0] * in_n[1];
        s1_x_next[5] = in_v[1] * in_n[0];
        for (int i = 0; i < 3; i++)
        begin
            s1_d_next[i] = in_v[i] * in_n[i];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg <= s1_x_next;
        s1_d_reg <= s1_d_next;
        s1_a_reg <= in_a;
        s1_b_reg <= in_b;
    end

    // stage 2: cross product w and dot product v.n
    logic signed [64:0]     s2_w_reg [3];
    logic signed [64:0]     s2_w_next [3];
    logic signed [65:0]     s2_p_reg;
    logic signed [65:0]     s2_p_next;
    logic signed [IN_W-1:0] s2_a_reg [3];
    logic signed [IN_W-1:0] s2_b_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_w_next[i] = 65'(s1_x_reg[2*i]) - 65'(s1_x_reg[2*i+1]);
        end
        s2_p_next = 66'(s1_d_reg[0]) + 66'(s1_d_reg[1]) + 66'(s1_d_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        s2_w_reg <= s2_w_next;
        s2_p_reg <= s2_p_next;
        s2_a_reg <= s1_a_reg;
        s2_b_reg <= s1_b_reg;
    end

    // stage 3: sign and magnitude
    logic [63:0]     s3_wm_reg [3];
    logic [63:0]     s3_wm_next [3];
    logic [IN_W-1:0] s3_am_reg [3];
    logic [IN_W-1:0] s3_am_next [3];
    logic [IN_W-1:0] s3_bm_reg [3];
    logic [IN_W-1:0] s3_bm_next [3];
    logic [2:0]      s3_sa_reg;
    logic [2:0]      s3_sa_next;
    logic [2:0]      s3_sb_reg;
    logic [2:0]      s3_sb_next;
    logic [63:0]     s3_pm_reg;
    logic [63:0]     s3_pm_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_wm_next[i] = s2_w_reg[i][64] ? 64'(-s2_w_reg[i]) : 64'(s2_w_reg[i]);
            s3_am_next[i] = s2_a_reg[i][IN_W-1] ? IN_W'(-s2_a_reg[i]) : IN_W'(s2_a_reg[i]);
            s3_bm_next[i] = s2_b_reg[i][IN_W-1] ? IN_W'(-s2_b_reg[i]) : IN_W'(s2_b_reg[i]);
            s3_sa_next[i] = s2_w_reg[i][64] ^ s2_a_reg[i][IN_W-1];
            s3_sb_next[i] = s2_w_reg[i][64] ^ s2_b_reg[i][IN_W-1];
        end
        s3_pm_next = s2_p_reg[65] ? 64'(-s2_p_reg) : 64'(s2_p_reg);
    end

    always_ff @(posedge clk)
    begin
        s3_wm_reg <= s3_wm_next;
        s3_am_reg <= s3_am_next;
        s3_bm_reg <= s3_bm_next;
        s3_sa_reg <= s3_sa_next;
        s3_sb_reg <= s3_sb_next;
        s3_pm_reg <= s3_pm_next;
    end

    // stage 4: 32x32 partial products
    logic [63:0] s4_al_reg [3];
    logic [63:0] s4_al_next [3];
    logic [63:0] s4_ah_reg [3];
    logic [63:0] s4_ah_next [3];
    logic [63:0] s4_bl_reg [3];
    logic [63:0] s4_bl_next [3];
    logic [63:0] s4_bh_reg [3];
    logic [63:0] s4_bh_next [3];
    logic [63:0] s4_ll_reg [3];
    logic [63:0] s4_ll_next [3];
    logic [63:0] s4_lh_reg [3];
    logic [63:0] s4_lh_next [3];
    logic [63:0] s4_hh_reg [3];
    logic [63:0] s4_hh_next [3];
    logic [63:0] s4_pll_reg;
    logic [63:0] s4_pll_next;
    logic [63:0] s4_plh_reg;
    logic [63:0] s4_plh_next;
    logic [63:0] s4_phh_reg;
    logic [63:0] s4_phh_next;
    logic [2:0]  s4_sa_reg;
    logic [2:0]  s4_sb_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_al_next[i] = s3_wm_reg[i][31:0] * s3_am_reg[i];
            s4_ah_next[i] = s3_wm_reg[i][63:32] * s3_am_reg[i];
            s4_bl_next[i] = s3_wm_reg[i][31:0] * s3_bm_reg[i];
            s4_bh_next[i] = s3_wm_reg[i][63:32] * s3_bm_reg[i];
            s4_ll_next[i] = s3_wm_reg[i][31:0] * s3_wm_reg[i][31:0];
            s4_lh_next[i] = s3_wm_reg[i][31:0] * s3_wm_reg[i][63:32];
            s4_hh_next[i] = s3_wm_reg[i][63:32] * s3_wm_reg[i][63:32];
        end
        s4_pll_next = s3_pm_reg[31:0] * s3_pm_reg[31:0];
        s4_plh_next = s3_pm_reg[31:0] * s3_pm_reg[63:32];
        s4_phh_next = s3_pm_reg[63:32] * s3_pm_reg[63:32];
    end

    always_ff @(posedge clk)
    begin
        s4_al_reg  <= s4_al_next;
        s4_ah_reg  <= s4_ah_next;
        s4_bl_reg  <= s4_bl_next;
        s4_bh_reg  <= s4_bh_next;
        s4_ll_reg  <= s4_ll_next;
        s4_lh_reg  <= s4_lh_next;
        s4_hh_reg  <= s4_hh_next;
        s4_pll_reg <= s4_pll_next;
        s4_plh_reg <= s4_plh_next;
        s4_phh_reg <= s4_phh_next;
        s4_sa_reg  <= s3_sa_reg;
        s4_sb_reg  <= s3_sb_reg;
    end

    // stage 5: signed terms and squares
    logic signed [97:0] s5_ta_reg [3];
    logic signed [97:0] s5_ta_next [3];
    logic signed [97:0] s5_tb_reg [3];
    logic signed [97:0] s5_tb_next [3];
    logic [127:0]       s5_sq_reg [3];
    logic [127:0]       s5_sq_next [3];
    logic [127:0]       s5_p2_reg;
    logic [127:0]       s5_p2_next;

    always_comb
    begin
        logic [95:0] mag_a;
        logic [95:0] mag_b;
        for (int i = 0; i < 3; i++)
        begin
            mag_a = (96'(s4_ah_reg[i]) << 32) + 96'(s4_al_reg[i]);
            mag_b = (96'(s4_bh_reg[i]) << 32) + 96'(s4_bl_reg[i]);
            s5_ta_next[i] = s4_sa_reg[i] ? -$signed({2'b00, mag_a}) : $signed({2'b00, mag_a});
            s5_tb_next[i] = s4_sb_reg[i] ? -$signed({2'b00, mag_b}) : $signed({2'b00, mag_b});
            s5_sq_next[i] = (128'(s4_hh_reg[i]) << 64) + (128'(s4_lh_reg[i]) << 33)
                          + 128'(s4_ll_reg[i]);
        end
        s5_p2_next = (128'(s4_phh_reg) << 64) + (128'(s4_plh_reg) << 33) + 128'(s4_pll_reg);
    end

    always_ff @(posedge clk)
    begin
        s5_ta_reg <= s5_ta_next;
        s5_tb_reg <= s5_tb_next;
        s5_sq_reg <= s5_sq_next;
        s5_p2_reg <= s5_p2_next;
    end

    // stage 6: side tests, c squared and r squared
    logic signed [99:0] s6_da;
    logic signed [99:0] s6_db;
    logic [129:0]       s6_c2_reg;
    logic [129:0]       s6_c2_next;
    logic [130:0]       s6_r2_reg;
    logic [130:0]       s6_r2_next;
    logic               s6_mi_reg;
    logic               s6_mi_next;
    logic               s6_ma_reg;
    logic               s6_ma_next;

    always_comb
    begin
        s6_da = 100'(s5_ta_reg[0]) + 100'(s5_ta_reg[1]) + 100'(s5_ta_reg[2]);
        s6_db = 100'(s5_tb_reg[0]) + 100'(s5_tb_reg[1]) + 100'(s5_tb_reg[2]);
        s6_c2_next = 130'(s5_sq_reg[0]) + 130'(s5_sq_reg[1]) + 130'(s5_sq_reg[2]);
        s6_r2_next = 131'(s6_c2_next) + 131'(s5_p2_reg);
        s6_mi_next = (s6_da > 0) && (s6_db < 0);
        s6_ma_next = (s6_da < 0) && (s6_db > 0);
    end

    always_ff @(posedge clk)
    begin
        s6_c2_reg <= s6_c2_next;
        s6_r2_reg <= s6_r2_next;
        s6_mi_reg <= s6_mi_next;
        s6_ma_reg <= s6_ma_next;
    end

    // square root of the ratio, one bit of q per stage from the top
    logic [DW-1:0]  sr_r_reg  [NSQ-1];
    logic [DW-1:0]  sr_y_reg  [NSQ-1];
    logic [130:0]   sr_r2_reg [NSQ-1];
    logic [QW-1:0]  sr_q_reg  [NSQ];
    logic           sr_mi_reg [NSQ];
    logic           sr_ma_reg [NSQ];

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        localparam int J = NSQ - 1 - k;
        logic [DW-1:0] r_in;
        logic [DW-1:0] y_in;
        logic [130:0]  r2_in;
        logic [QW-1:0] q_in;
        logic          mi_in;
        logic          ma_in;
        logic [DW-1:0] delta;
        logic          take;
        logic [QW-1:0] q_next;

        if (k == 0)
        begin : g_first
            assign r_in  = DW'(s6_c2_reg) << (2 * FRAC_BITS + 4);
            assign y_in  = '0;
            assign r2_in = s6_r2_reg;
            assign q_in  = '0;
            assign mi_in = s6_mi_reg;
            assign ma_in = s6_ma_reg;
        end
        else
        begin : g_rest
            assign r_in  = sr_r_reg[k-1];
            assign y_in  = sr_y_reg[k-1];
            assign r2_in = sr_r2_reg[k-1];
            assign q_in  = sr_q_reg[k-1];
            assign mi_in = sr_mi_reg[k-1];
            assign ma_in = sr_ma_reg[k-1];
        end

        assign delta  = (y_in << (J + 1)) + (DW'(r2_in) << (2 * J));
        assign take   = (delta <= r_in);
        assign q_next = take ? (q_in | (QW'(1) << J)) : q_in;

        always_ff @(posedge clk)
        begin
            sr_q_reg[k]  <= q_next;
            sr_mi_reg[k] <= mi_in;
            sr_ma_reg[k] <= ma_in;
        end

        if (k < NSQ - 1)
        begin : g_carry
            logic [DW-1:0] r_next;
            logic [DW-1:0] y_next;

            assign r_next = take ? (r_in - delta) : r_in;
            assign y_next = take ? (y_in + (DW'(r2_in) << J)) : y_in;

            always_ff @(posedge clk)
            begin
                sr_r_reg[k]  <= r_next;
                sr_y_reg[k]  <= y_next;
                sr_r2_reg[k] <= r2_in;
            end
        end
    end

    // output stage: round, form bounds, saturate
    logic [QW:0]    out_q1;
    logic [MW-1:0]  out_m;
    logic [EW-1:0]  out_min;
    logic [EW-1:0]  out_max;
    acb_rsp_t       result_reg;
    acb_rsp_t       result_next;

    always_comb
    begin
        out_q1  = (QW+1)'(sr_q_reg[NSQ-1]) + (QW+1)'(1);
        out_m   = MW'(out_q1 >> 1);
        out_min = sr_mi_reg[NSQ-1] ? (TWO_E - EW'(out_m)) : FOUR_E;
        out_max = sr_ma_reg[NSQ-1] ? (TWO_E + EW'(out_m)) : '0;
        result_next.min_chord_sq = (|out_min[EW-1:OUT_W]) ? '1 : out_min[OUT_W-1:0];
        result_next.max_chord_sq = (|out_max[EW-1:OUT_W]) ? '1 : out_max[OUT_W-1:0];
        result_next.min_interior = sr_mi_reg[NSQ-1];
        result_next.max_interior = sr_ma_reg[NSQ-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

    `ACB_ASSERT_NEVER(a_interior_excl, done && result.min_interior && result.max_interior, "both interior flags set")
    `ACB_ASSERT_IMP(a_min_outside, done && !result.min_interior, result.min_chord_sq == FOUR_SAT, "minimum outside arc is not four")
    `ACB_ASSERT_IMP(a_max_outside, done && !result.max_interior, result.max_chord_sq == '0, "maximum outside arc is not zero")
    `ACB_ASSERT_IMP(a_min_range, done && result.min_interior, result.min_chord_sq <= TWO_SAT, "interior minimum above two")

endmodule
